### hw/rtl/ktb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktb_pkg
// Shared types and constants for the keyed token bucket table.
// ----------------------------------------------------------------------------
package ktb_pkg;

  typedef struct packed {
    logic        mode;
    logic [62:0] endpoint_key;
    logic [62:0] now_us;
    logic [31:0] fill_rate;
    logic [19:0] burst_size;
  } ktb_in_t;

  typedef struct packed {
    logic       allowed;
    logic [2:0] outcome;
    logic       bucket_created;
    logic [5:0] slot_index;
  } ktb_out_t;

  // search record handed from cell to cell (slot numbers travel beside it)
  typedef struct packed {
    logic        found;
    logic [51:0] tokens;
    logic [62:0] last;
    logic        free;
    logic        old;
    logic [62:0] old_age;
  } ktb_srch_t;

  // write command broadcast to every cell
  typedef struct packed {
    logic        clr;
    logic        en;
    logic [62:0] key;
    logic [51:0] tokens;
    logic [62:0] last;
  } ktb_wr_t;

  localparam logic [2:0] OUT_GRANTED   = 3'd0;
  localparam logic [2:0] OUT_DENIED    = 3'd1;
  localparam logic [2:0] OUT_DISABLED  = 3'd2;
  localparam logic [2:0] OUT_UNTRACKED = 3'd3;
  localparam logic [2:0] OUT_CLEARED   = 3'd4;

  localparam logic [52:0] UNITS_PER_TOKEN = 53'd4096000000;
  localparam logic [52:0] US_PER_SECOND   = 53'd1000000;
  localparam logic [39:0] STALE_RESET     = 40'd600000000;

endpackage

### hw/rtl/ktb_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktb_cell
// One bucket of the table; folds itself into the passing search record.
// ----------------------------------------------------------------------------
module ktb_cell #(
  parameter int SW  = 6,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [62:0]       key,
  input  logic [62:0]       now,
  input  logic [39:0]       thresh,
  input  ktb_pkg::ktb_srch_t rec_in,
  input  logic [SW-1:0]     hit_slot_in,
  input  logic [SW-1:0]     free_slot_in,
  input  logic [SW-1:0]     old_slot_in,
  output ktb_pkg::ktb_srch_t rec_out,
  output logic [SW-1:0]     hit_slot_out,
  output logic [SW-1:0]     free_slot_out,
  output logic [SW-1:0]     old_slot_out,
  input  ktb_pkg::ktb_wr_t  wr,
  input  logic [SW-1:0]     wr_slot
);
  import ktb_pkg::*;

  logic        v_r;
  logic [62:0] key_r;
  logic [51:0] tok_r;
  logic [62:0] last_r;

  ktb_srch_t     rec_r, rec_nxt;
  logic [SW-1:0] hs_r, hs_nxt, fs_r, fs_nxt, os_r, os_nxt;

  logic        hit, stale;
  logic [62:0] age;

  // compare against this bucket
  assign hit   = v_r && (key_r == key);
  assign age   = now - last_r;
  assign stale = v_r && !hit && (now > last_r) && (age > {23'd0, thresh}) &&
                 (age > rec_in.old_age);

  always_comb begin
    rec_nxt = rec_in;
    hs_nxt  = hit_slot_in;
    fs_nxt  = free_slot_in;
    os_nxt  = old_slot_in;
    if (!rec_in.found) begin
      if (hit) begin
        rec_nxt.found  = 1'b1;
        rec_nxt.tokens = tok_r;
        rec_nxt.last   = last_r;
        hs_nxt         = SW'(IDX);
      end else if (!v_r) begin
        if (!rec_in.free) begin
          rec_nxt.free = 1'b1;
          fs_nxt       = SW'(IDX);
        end
      end else if (stale) begin
        rec_nxt.old     = 1'b1;
        rec_nxt.old_age = age;
        os_nxt          = SW'(IDX);
      end
    end
  end

  // hand the record on
  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
    hs_r  <= hs_nxt;
    fs_r  <= fs_nxt;
    os_r  <= os_nxt;
  end

  assign rec_out       = rec_r;
  assign hit_slot_out  = hs_r;
  assign free_slot_out = fs_r;
  assign old_slot_out  = os_r;

  // bucket storage
  always_ff @(posedge clk) begin
    if (!rst_n || wr.clr) begin
      v_r <= 1'b0;
    end else if (wr.en && (wr_slot == SW'(IDX))) begin
      v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr_slot == SW'(IDX))) begin
      key_r  <= wr.key;
      tok_r  <= wr.tokens;
      last_r <= wr.last;
    end
  end

endmodule

### hw/rtl/keyed_token_bucket_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_token_bucket_table_core
// Per-key token bucket limiter over a chain of bucket cells.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_ready as one beat of in_data; one result beat
// leaves on out_valid/out_ready for every request. cfg_wr_en/cfg_wr_data set
// the stale threshold for eviction, taken at any edge with the enable high.
// An acquire walks a search record down the row of TABLE_DEPTH cells, one
// cell per cycle, then decides; if it found its bucket, a free one or a stale
// one, it runs the refill arithmetic (MUL1, MUL2, SUM) and writes back in FIN.
// Clear and rate-zero requests skip the walk and go straight to FIN.
// One request is worked at a time; the next beat is taken once the result is
// in the output register, even while the receiver stalls it. A stalled
// result holds the block in its final step until the output drains.
// Reset empties every bucket at once and loads the threshold default.
// ----------------------------------------------------------------------------
module keyed_token_bucket_table_core #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ktb_pkg::ktb_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ktb_pkg::ktb_out_t out_data,
  input  logic              cfg_wr_en,
  input  logic [39:0]       cfg_wr_data
);
  import ktb_pkg::*;

  localparam int SW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_MUL1   = 3'd3;
  localparam logic [2:0] ST_MUL2   = 3'd4;
  localparam logic [2:0] ST_SUM    = 3'd5;
  localparam logic [2:0] ST_FIN    = 3'd6;

  logic [2:0]    st_r;
  logic [SW-1:0] cnt_r;
  ktb_in_t       req_r;
  logic [39:0]   thresh_r;
  logic [52:0]   cap_r, tok_r, room_r, newtok_r;
  logic [62:0]   last_r, el_r;
  logic [SW-1:0] slot_r;
  logic          created_r, refill_r, big_r, tge_r, norm_r, wr_en_r, clr_r;
  logic [57:0]   plo_r;
  logic [58:0]   phi_r;
  ktb_out_t      res_r, out_r;
  logic          out_valid_r;

  ktb_srch_t     rec [0:TABLE_DEPTH];
  logic [SW-1:0] hs [0:TABLE_DEPTH];
  logic [SW-1:0] fs [0:TABLE_DEPTH];
  logic [SW-1:0] os [0:TABLE_DEPTH];
  ktb_wr_t       wr;

  logic          fire, in_fire, grant;
  logic [62:0]   el;
  logic [85:0]   prod;
  ktb_out_t      fin_res;

  assign in_ready  = (st_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign fire      = (st_r == ST_FIN) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // head of the chain starts empty
  assign rec[0] = '0;
  assign hs[0]  = '0;
  assign fs[0]  = '0;
  assign os[0]  = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    ktb_cell #(.SW(SW), .IDX(i)) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .key          (req_r.endpoint_key),
      .now          (req_r.now_us),
      .thresh       (thresh_r),
      .rec_in       (rec[i]),
      .hit_slot_in  (hs[i]),
      .free_slot_in (fs[i]),
      .old_slot_in  (os[i]),
      .rec_out      (rec[i+1]),
      .hit_slot_out (hs[i+1]),
      .free_slot_out(fs[i+1]),
      .old_slot_out (os[i+1]),
      .wr           (wr),
      .wr_slot      (slot_r)
    );
  end

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= STALE_RESET;
    end else if (cfg_wr_en) begin
      thresh_r <= cfg_wr_data;
    end
  end

  // refill arithmetic
  assign el   = req_r.now_us - last_r;
  assign prod = {1'b0, phi_r, 26'd0} + {28'd0, plo_r};
  assign grant = (newtok_r >= UNITS_PER_TOKEN);

  always_comb begin
    fin_res = res_r;
    if (norm_r) begin
      fin_res.allowed        = grant;
      fin_res.outcome        = grant ? OUT_GRANTED : OUT_DENIED;
      fin_res.bucket_created = created_r;
      fin_res.slot_index     = 6'(slot_r);
    end
  end

  // write-back command
  always_comb begin
    wr        = '0;
    wr.clr    = fire && clr_r;
    wr.en     = fire && wr_en_r;
    wr.key    = req_r.endpoint_key;
    wr.tokens = grant ? 52'(newtok_r - UNITS_PER_TOKEN) : newtok_r[51:0];
    wr.last   = refill_r ? req_r.now_us : last_r;
  end

  // output beat valid: load on finish, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      cnt_r <= '0;
    end else begin
      unique case (st_r)
        ST_IDLE: begin
          cnt_r <= '0;
          if (in_fire) begin
            if (in_data.mode || (in_data.fill_rate == 32'd0)) begin
              st_r <= ST_FIN;
            end else begin
              st_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == SW'(TABLE_DEPTH - 1)) begin
            st_r <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (rec[TABLE_DEPTH].found || rec[TABLE_DEPTH].free || rec[TABLE_DEPTH].old) begin
            st_r <= ST_MUL1;
          end else begin
            st_r <= ST_FIN;
          end
        end
        ST_MUL1: st_r <= ST_MUL2;
        ST_MUL2: st_r <= ST_SUM;
        ST_SUM:  st_r <= ST_FIN;
        ST_FIN: begin
          if (fire) begin
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= fin_res;
    end
    unique case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          req_r     <= in_data;
          norm_r    <= 1'b0;
          wr_en_r   <= 1'b0;
          clr_r     <= in_data.mode;
          created_r <= 1'b0;
          res_r.allowed        <= !in_data.mode;
          res_r.outcome        <= in_data.mode ? OUT_CLEARED : OUT_DISABLED;
          res_r.bucket_created <= 1'b0;
          res_r.slot_index     <= '0;
        end
      end
      ST_SCAN: begin
        if (req_r.burst_size != 20'd0) begin
          cap_r <= 53'(53'(req_r.burst_size) * UNITS_PER_TOKEN);
        end else begin
          cap_r <= 53'(53'(req_r.fill_rate) * US_PER_SECOND);
        end
      end
      ST_DECIDE: begin
        res_r.allowed <= 1'b1;
        res_r.outcome <= OUT_UNTRACKED;
        if (rec[TABLE_DEPTH].found) begin
          slot_r  <= hs[TABLE_DEPTH];
          tok_r   <= {1'b0, rec[TABLE_DEPTH].tokens};
          last_r  <= rec[TABLE_DEPTH].last;
          norm_r  <= 1'b1;
          wr_en_r <= 1'b1;
        end else if (rec[TABLE_DEPTH].free || rec[TABLE_DEPTH].old) begin
          slot_r    <= rec[TABLE_DEPTH].free ? fs[TABLE_DEPTH] : os[TABLE_DEPTH];
          tok_r     <= {1'b0, cap_r[51:0]};
          last_r    <= req_r.now_us;
          created_r <= 1'b1;
          norm_r    <= 1'b1;
          wr_en_r   <= 1'b1;
        end
      end
      ST_MUL1: begin
        el_r     <= el;
        refill_r <= (req_r.now_us > last_r);
        plo_r    <= el[25:0] * req_r.fill_rate;
        big_r    <= (el[62:53] != 10'd0);
        tge_r    <= (tok_r >= cap_r);
        room_r   <= cap_r - tok_r;
      end
      ST_MUL2: begin
        phi_r <= el_r[52:26] * req_r.fill_rate;
      end
      ST_SUM: begin
        if (!refill_r) begin
          newtok_r <= tok_r;
        end else if (big_r || tge_r || (prod > {33'd0, room_r})) begin
          newtok_r <= cap_r;
        end else begin
          newtok_r <= tok_r + prod[52:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule
